[src/pku_pkg.sv]
`default_nettype none

package pku_pkg;

  // Block size limit for the position counter
  localparam int BLOCK_BYTES = 512;
  localparam int POS_W       = $clog2(BLOCK_BYTES + 1);

  localparam int LEN_W       = 10;
  localparam logic [LEN_W-1:0] LEN_MAX     = '1;
  localparam logic [LEN_W-1:0] MAX_OUT_RST = LEN_W'(512);

  localparam logic [7:0] PAD_FILL = 8'hFF;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Parse phase, one-hot
  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_TYPE   = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  // Final status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_PREFIX  = 3'd2,
    ST_TYPE    = 3'd3,
    ST_NOSTART = 3'd4,
    ST_LONG    = 3'd5
  } status_t;

  // Block type codes
  localparam logic [1:0] BT_ZERO = 2'd0;
  localparam logic [1:0] BT_ONE  = 2'd1;

  // Classified result record handed from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic             send;
    logic             last;
    status_t          status;
    logic [LEN_W-1:0] len;
    logic             irr;
  } rec_t;

endpackage

`default_nettype wire

[src/pkcs1_v15_unpad_stream_unit.sv]
`default_nettype none
// A result is stored in a queue entry and then loaded into the output register.
// Throughput: one byte per cycle while the queue has space; a two-entry queue and the output register absorb stalls.
// Bytes that produce no result (prefix, type, padding) are still consumed but not pushed to the queue.
// Reset (rst, synchronous, active high) clears parse state and queue and sets the
// output length limit to 512.

module pkcs1_v15_unpad_stream_unit import pku_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output logic [7:0]            out_byte,
  output logic                  out_valid,
  output logic                  done_res,
  output logic [2:0]            final_status,
  output logic [LEN_W-1:0]      payload_len,
  output logic                  pad_irregular
);

  logic q_space, q_push, q_pop, q_avail;
  rec_t push_rec, pop_rec;

  pku_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_space   (q_space),
    .q_push    (q_push),
    .q_rec     (push_rec)
  );

  pku_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .space    (q_space),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_rec  (pop_rec)
  );

  pku_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_avail       (q_avail),
    .q_rec         (pop_rec),
    .q_pop         (q_pop),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .done_res      (done_res),
    .final_status  (final_status),
    .payload_len   (payload_len),
    .pad_irregular (pad_irregular)
  );

endmodule

`default_nettype wire

[src/pku_front.sv]
`default_nettype none

module pku_front import pku_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data,
  input  wire logic             q_space,
  output logic                  q_push,
  output rec_t                  q_rec
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  phase_t           phase, phase_next;
  logic [1:0]       block_type, block_type_next;
  status_t          error_code, error_code_next;
  logic [LEN_W-1:0] payload_count, payload_count_next;
  logic             irregular_flag, irregular_flag_next;
  logic [LEN_W-1:0] max_out_len;

  logic    take, send, short_block, accept;
  status_t err_t;

  assign in_ready  = q_space;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Classify one byte and compute the next parse state
  always_comb begin
    phase_next          = phase;
    block_type_next     = block_type;
    err_t               = error_code;
    payload_count_next  = payload_count;
    irregular_flag_next = irregular_flag;
    take                = 1'b0;
    send                = 1'b0;

    case (phase)
      PH_PREFIX: begin
        if (in_byte != 8'd0 && err_t == ST_OK) err_t = ST_PREFIX;
        phase_next = PH_TYPE;
      end
      PH_TYPE: begin
        if (in_byte > 8'd2) begin
          if (err_t == ST_OK) err_t = ST_TYPE;
        end else begin
          block_type_next = in_byte[1:0];
        end
        phase_next = PH_PAD;
      end
      PH_PAD: begin
        if (error_code == ST_OK) begin
          if (block_type == BT_ZERO) begin
            if (in_byte != 8'd0) begin
              phase_next = PH_DATA;
              take       = 1'b1;
            end
          end else begin
            if (block_type == BT_ONE && in_byte != 8'd0 && in_byte != PAD_FILL)
              irregular_flag_next = 1'b1;
            if (in_byte == 8'd0) phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: take = 1'b1;
      default: phase_next = PH_PREFIX;
    endcase

    // Count a payload byte; send it only while no error stands
    if (take && (error_code == ST_OK || error_code == ST_LONG)) begin
      if (payload_count >= max_out_len && err_t == ST_OK) err_t = ST_LONG;
      if (payload_count != LEN_MAX) payload_count_next = payload_count + LEN_W'(1);
      send = (err_t == ST_OK);
    end
    error_code_next = err_t;

    short_block = in_last && (byte_position < POS_W'(2));
    byte_position_next = byte_position;
    if (byte_position < POS_W'(BLOCK_BYTES))
      byte_position_next = byte_position + POS_W'(1);
  end

  // Build the record for the queue
  always_comb begin
    q_rec.data   = in_byte;
    q_rec.send   = send;
    q_rec.last   = in_last;
    q_rec.irr    = irregular_flag_next;
    q_rec.len    = short_block ? '0 : payload_count_next;
    if (short_block)
      q_rec.status = ST_SHORT;
    else if (err_t == ST_OK && phase_next != PH_DATA)
      q_rec.status = ST_NOSTART;
    else
      q_rec.status = err_t;
    q_push = accept && (send || in_last);
  end

  // Advance state on each input transfer; clear at block end
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      phase          <= PH_PREFIX;
      block_type     <= BT_ZERO;
      error_code     <= ST_OK;
      payload_count  <= '0;
      irregular_flag <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        byte_position  <= '0;
        phase          <= PH_PREFIX;
        block_type     <= BT_ZERO;
        error_code     <= ST_OK;
        payload_count  <= '0;
        irregular_flag <= 1'b0;
      end else begin
        byte_position  <= byte_position_next;
        phase          <= phase_next;
        block_type     <= block_type_next;
        error_code     <= error_code_next;
        payload_count  <= payload_count_next;
        irregular_flag <= irregular_flag_next;
      end
    end
  end

  // Hold the output length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_len <= MAX_OUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_out_len <= cfg_data;
    end
  end

endmodule

`default_nettype wire

[src/pku_queue.sv]
`default_nettype none

module pku_queue import pku_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rec_t push_rec,
  output logic      space,
  input  wire logic pop,
  output logic      avail,
  output rec_t      pop_rec
);

  rec_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign space   = (count != QCNT_W'(QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign pop_rec = entries[rd_ptr];

  // Store records
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/pku_back.sv]
`default_nettype none

module pku_back import pku_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_avail,
  input  wire rec_t             q_rec,
  output logic                  q_pop,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output logic [7:0]            out_byte,
  output logic                  out_valid,
  output logic                  done_res,
  output logic [2:0]            final_status,
  output logic [LEN_W-1:0]      payload_len,
  output logic                  pad_irregular
);

  logic load;

  assign load  = q_avail && (!res_valid || res_ready);
  assign q_pop = load;

  // Track output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Format the result; zero the fields that do not apply
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= q_rec.send ? q_rec.data : 8'd0;
      out_valid     <= q_rec.send;
      done_res      <= q_rec.last;
      final_status  <= q_rec.last ? q_rec.status : ST_OK;
      payload_len   <= q_rec.last ? q_rec.len : '0;
      pad_irregular <= q_rec.last && q_rec.irr;
    end
  end

endmodule

`default_nettype wire
